// ===== src/mkey_pkg.sv =====
// ----------------------------------------------------------------------------
// mkey_pkg
// Shared widths, register indexes and lane/merge types for the 3d morton key
// block.
// ----------------------------------------------------------------------------
package mkey_pkg;

   localparam int POS_W          = 48;
   localparam int INDEX_W        = 31;
   localparam int KEY_W          = 63;
   localparam int CSR_W          = 48;
   localparam int CSR_ADDR_W     = 3;
   localparam int REQ_DATA_W     = 176;
   localparam int RSP_DATA_W     = 96;
   localparam int LEVEL_BITS_MAX = 21;
   localparam int LEVEL_BITS_DEF = 21;
   // integer part of the product: bits 56 and up of a 97 bit sum window
   localparam int IP_W           = 41;

   localparam logic [CSR_ADDR_W-1:0] CSR_CORNER_X   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CORNER_Y   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CORNER_Z   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_SCALE = 3'd3;

   localparam logic [CSR_W-1:0] GRID_SCALE_RESET = 48'h0001_0000_0000;

   typedef struct packed {
      logic [LEVEL_BITS_MAX-1:0] coord;
      logic                      clip;
   } lane_res_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               last;
   } side_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [INDEX_W-1:0] index;
      logic               clamped;
      logic               last;
   } rsp_word_type;

endpackage

// ===== src/mkey_axis_lane.sv =====
// ----------------------------------------------------------------------------
// mkey_axis_lane
// One axis: corner subtract, split 48x48 multiply, partial product sum and
// clamp of the integer part to the grid range. Four register stages.
// ----------------------------------------------------------------------------
module mkey_axis_lane
   import mkey_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [POS_W-1:0] pos,
   input  logic signed [POS_W-1:0] corner,
   input  logic        [CSR_W-1:0] scale,
   output lane_res_type            res
);

   localparam logic [LEVEL_BITS-1:0] COORD_MAX = {LEVEL_BITS{1'b1}};

   // stage 1: difference, nonpositive values forced to zero
   logic signed [POS_W:0] diff;
   logic [POS_W-1:0]      d_in, d_ff;
   logic                  clip1_in, clip1_ff;

   // stage 2: partial products
   logic [63:0] pp_ll_in, pp_ll_ff;
   logic [47:0] pp_hl_in, pp_hl_ff;
   logic [47:0] pp_lh_in, pp_lh_ff;
   logic [31:0] pp_hh_in, pp_hh_ff;
   logic        clip2_ff;

   // stage 3: column sums
   logic [33:0] t_in, t_ff;
   logic [32:0] hs_in, hs_ff;
   logic        clip3_ff;

   // stage 4: integer part and clamp
   logic [32:0]     phi;
   logic [IP_W-1:0] ip;
   logic            over;
   lane_res_type    res_in, res_ff;

   always_comb begin
      diff     = {pos[POS_W-1], pos} - {corner[POS_W-1], corner};
      d_in     = (!diff[POS_W] && (diff != '0)) ? diff[POS_W-1:0] : '0;
      clip1_in = diff[POS_W] && (scale != '0);
   end

   always_comb begin
      pp_ll_in = 64'(d_ff[31:0])  * 64'(scale[31:0]);
      pp_hl_in = 48'(d_ff[47:32]) * 48'(scale[31:0]);
      pp_lh_in = 48'(d_ff[31:0])  * 48'(scale[47:32]);
      pp_hh_in = 32'(d_ff[47:32]) * 32'(scale[47:32]);
   end

   always_comb begin
      t_in  = 34'(pp_ll_ff[63:32]) + 34'(pp_hl_ff[31:0]) + 34'(pp_lh_ff[31:0]);
      hs_in = 33'(pp_hh_ff) + 33'(pp_hl_ff[47:32]) + 33'(pp_lh_ff[47:32]);
   end

   always_comb begin
      phi  = hs_ff + 33'(t_ff[33:32]);
      ip   = {phi, t_ff[31:24]};
      over = |ip[IP_W-1:LEVEL_BITS];
      res_in.coord = '0;
      res_in.coord[LEVEL_BITS-1:0] = over ? COORD_MAX : ip[LEVEL_BITS-1:0];
      res_in.clip  = clip3_ff || over;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= d_in;
         clip1_ff <= clip1_in;
         pp_ll_ff <= pp_ll_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_hh_ff <= pp_hh_in;
         clip2_ff <= clip1_ff;
         t_ff     <= t_in;
         hs_ff    <= hs_in;
         clip3_ff <= clip2_ff;
         res_ff   <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== src/mkey_merge.sv =====
// ----------------------------------------------------------------------------
// mkey_merge
// Interleaves the three lane coordinates into the morton key, ors the clamp
// flags and holds the result word in the output register.
// ----------------------------------------------------------------------------
module mkey_merge
   import mkey_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic         clock,
   input  logic         en,
   input  lane_res_type res_x,
   input  lane_res_type res_y,
   input  lane_res_type res_z,
   input  side_type     side,
   output rsp_word_type word
);

   rsp_word_type word_in, word_ff;

   always_comb begin
      word_in.key = '0;
      // x takes the top bit of each triple, z the bottom
      for (int k = 0; k < LEVEL_BITS; k++) begin
         word_in.key[3*k+2] = res_x.coord[k];
         word_in.key[3*k+1] = res_y.coord[k];
         word_in.key[3*k]   = res_z.coord[k];
      end
      word_in.index   = side.index;
      word_in.clamped = res_x.clip || res_y.clip || res_z.clip;
      word_in.last    = side.last;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule

// ===== src/morton_key_3d_from_position.sv =====
// ----------------------------------------------------------------------------
// morton_key_3d_from_position
// Pipeline: 5 register stages (4 in each axis lane for subtract, split
//   multiply, partial sums and clamp, plus the output register of the merge
//   stage).
// Throughput: one word per cycle; the whole pipe holds only while a rsp word
//   waits on rsp_tready.
// Reset: synchronous, clears the pipe valids and loads the register defaults.
// ----------------------------------------------------------------------------
module morton_key_3d_from_position
   import mkey_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: pos_x[47:0], pos_y[95:48], pos_z[143:96],
   //            particle_index[174:144], zero[175]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // rsp_tdata: morton_key[62:0], index_out[93:63], zero[95:94]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: clamped
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int STAGES = 5;
   localparam logic [LEVEL_BITS_MAX-1:0] COORD_MAX =
      LEVEL_BITS_MAX'((64'd1 << LEVEL_BITS) - 64'd1);

   logic [CSR_W-1:0] corner_x_ff, corner_y_ff, corner_z_ff, grid_scale_ff;

   logic              en;
   logic [STAGES-1:0] vld_in, vld_ff;
   side_type          side_in;
   side_type          side_ff [0:STAGES-2];
   lane_res_type      res_x, res_y, res_z;
   rsp_word_type      word;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_x_ff   <= '0;
         corner_y_ff   <= '0;
         corner_z_ff   <= '0;
         grid_scale_ff <= GRID_SCALE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CORNER_X:   corner_x_ff   <= csr_wdata;
            CSR_CORNER_Y:   corner_y_ff   <= csr_wdata;
            CSR_CORNER_Z:   corner_z_ff   <= csr_wdata;
            CSR_GRID_SCALE: grid_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipe moves when the output register is empty or being drained
   assign en         = !vld_ff[STAGES-1] || rsp_tready;
   assign req_tready = en;

   assign vld_in        = {vld_ff[STAGES-2:0], req_tvalid};
   assign side_in.index = req_tdata[3*POS_W +: INDEX_W];
   assign side_in.last  = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < STAGES-1; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   mkey_axis_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_x (
      .clock  (clock),
      .en     (en),
      .pos    (req_tdata[0 +: POS_W]),
      .corner (corner_x_ff),
      .scale  (grid_scale_ff),
      .res    (res_x)
   );

   mkey_axis_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_y (
      .clock  (clock),
      .en     (en),
      .pos    (req_tdata[POS_W +: POS_W]),
      .corner (corner_y_ff),
      .scale  (grid_scale_ff),
      .res    (res_y)
   );

   mkey_axis_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_z (
      .clock  (clock),
      .en     (en),
      .pos    (req_tdata[2*POS_W +: POS_W]),
      .corner (corner_z_ff),
      .scale  (grid_scale_ff),
      .res    (res_z)
   );

   mkey_merge #(.LEVEL_BITS(LEVEL_BITS)) u_merge (
      .clock (clock),
      .en    (en),
      .res_x (res_x),
      .res_y (res_y),
      .res_z (res_z),
      .side  (side_ff[STAGES-2]),
      .word  (word)
   );

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = {2'b00, word.index, word.key};
   assign rsp_tuser  = word.clamped;
   assign rsp_tlast  = word.last;

   // a held pipe keeps every in-flight word
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipe valids moved while stalled");

   // a clamped nonzero coordinate can only be the top of the grid
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-2] && res_x.clip && (res_x.coord != '0) |-> res_x.coord == COORD_MAX)
      else $error("x lane clamp gave a value other than the grid maximum");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp word valid right after reset");

endmodule
